>>> hw/rtl/lap3rgb_pkg.sv
// ----------------------------------------------------------------------------
// lap3rgb_pkg
// Shared constants and types of the 3x3 RGB Laplacian edge filter.
// ----------------------------------------------------------------------------
package lap3rgb_pkg;

    // Frame geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WEFF_BITS  = COL_BITS + 1;
    localparam int OROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int IROW_BITS  = OROW_BITS + 1;

    // Pixel and arithmetic widths
    localparam int CHANNEL_BITS = 8;
    localparam int NUM_CHANNELS = 3;
    localparam int PIX_BITS     = NUM_CHANNELS * CHANNEL_BITS;
    localparam int SUM_BITS     = CHANNEL_BITS + 3;
    localparam int MAG_BITS     = CHANNEL_BITS + 2;
    localparam int GAIN_BITS    = 8;
    localparam int PROD_BITS    = MAG_BITS + GAIN_BITS;

    // Configuration registers
    localparam int DIM_BITS       = 13;
    localparam int CFG_DATA_BITS  = DIM_BITS;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = DIM_BITS'(512);
    localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = DIM_BITS'(512);
    localparam logic [GAIN_BITS-1:0] GAIN_RESET   = GAIN_BITS'(10);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_MAGNITUDE_GAIN = 2'd2
    } t_cfg_index;

    // Output queue
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Border replacement flags travelling with a result
    typedef struct packed {
        logic lf_rep;
        logic rt_rep;
        logic up_rep;
        logic dn_rep;
        logic last;
    } t_border;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] edge_two;
        logic [CHANNEL_BITS-1:0] edge_one;
        logic [CHANNEL_BITS-1:0] edge_zero;
        logic                    frame_last;
    } t_result;

endpackage

>>> hw/rtl/lap3rgb_ram.sv
// ----------------------------------------------------------------------------
// lap3rgb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lap3rgb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/laplacian_3x3_rgb_mirror.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_rgb_mirror
// 4-neighbour Laplacian per RGB channel, reflect-101 borders, gained and
// saturated magnitude output.
// ----------------------------------------------------------------------------
// Timing: a result passes the stage 1, stage 2 and result queue registers before
//   it is valid; the result of pixel k is caused by input item k + width + 1.
// Throughput: 1 item per unstalled clock, set by one read-modify-write of line
//   memory per item (registered read, forwarded on back-to-back same address).
// Output: 4-entry result queue; input stalls when queue plus pipeline is full.
// Reset: counters, window and pipeline clear, registers take their defaults;
//   the line memory is not cleared.
module laplacian_3x3_rgb_mirror (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // pixel input
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [lap3rgb_pkg::CHANNEL_BITS-1:0]    i_channel_zero,
    input  logic [lap3rgb_pkg::CHANNEL_BITS-1:0]    i_channel_one,
    input  logic [lap3rgb_pkg::CHANNEL_BITS-1:0]    i_channel_two,
    input  logic                                    i_drain,
    // result output
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [lap3rgb_pkg::CHANNEL_BITS-1:0]    o_edge_zero,
    output logic [lap3rgb_pkg::CHANNEL_BITS-1:0]    o_edge_one,
    output logic [lap3rgb_pkg::CHANNEL_BITS-1:0]    o_edge_two,
    output logic                                    o_frame_last,
    // configuration write
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [lap3rgb_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [lap3rgb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int PB = lap3rgb_pkg::PIX_BITS;
    localparam int CB = lap3rgb_pkg::CHANNEL_BITS;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    logic [lap3rgb_pkg::DIM_BITS-1:0]   r_width;
    logic [lap3rgb_pkg::DIM_BITS-1:0]   r_height;
    logic [lap3rgb_pkg::GAIN_BITS-1:0]  r_gain;
    logic                               cfg_wr;
    logic                               cfg_geom;
    lap3rgb_pkg::t_cfg_index            cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_idx     = lap3rgb_pkg::t_cfg_index'(i_cfg_index);
    assign cfg_geom    = cfg_wr && ((cfg_idx == lap3rgb_pkg::CFG_IMAGE_WIDTH) ||
                                    (cfg_idx == lap3rgb_pkg::CFG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lap3rgb_pkg::WIDTH_RESET;
            r_height <= lap3rgb_pkg::HEIGHT_RESET;
            r_gain   <= lap3rgb_pkg::GAIN_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                lap3rgb_pkg::CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data;
                lap3rgb_pkg::CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data;
                lap3rgb_pkg::CFG_MAGNITUDE_GAIN:
                    r_gain <= i_cfg_data[lap3rgb_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry, clamped to 2..max
    logic [lap3rgb_pkg::WEFF_BITS-1:0]  w_eff;
    logic [lap3rgb_pkg::IROW_BITS-1:0]  h_eff;

    always_comb begin
        if (int'(r_width) < 2) begin
            w_eff = lap3rgb_pkg::WEFF_BITS'(2);
        end else if (int'(r_width) > lap3rgb_pkg::MAX_WIDTH) begin
            w_eff = lap3rgb_pkg::WEFF_BITS'(lap3rgb_pkg::MAX_WIDTH);
        end else begin
            w_eff = lap3rgb_pkg::WEFF_BITS'(r_width);
        end
        if (int'(r_height) < 2) begin
            h_eff = lap3rgb_pkg::IROW_BITS'(2);
        end else if (int'(r_height) > lap3rgb_pkg::MAX_HEIGHT) begin
            h_eff = lap3rgb_pkg::IROW_BITS'(lap3rgb_pkg::MAX_HEIGHT);
        end else begin
            h_eff = lap3rgb_pkg::IROW_BITS'(r_height);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: accept, counters, memory read
    // ------------------------------------------------------------------------
    logic [lap3rgb_pkg::COL_BITS-1:0]   r_in_col,  n_in_col;
    logic [lap3rgb_pkg::IROW_BITS-1:0]  r_in_row,  n_in_row;
    logic [lap3rgb_pkg::COL_BITS-1:0]   r_out_col, n_out_col;
    logic [lap3rgb_pkg::OROW_BITS-1:0]  r_out_row, n_out_row;

    logic                               in_acc;
    logic                               drain_phase;
    logic                               act;
    logic                               emit;
    logic                               s0_emit;
    logic [PB-1:0]                      px_in;
    logic [lap3rgb_pkg::WEFF_BITS-1:0]  in_col_inc;
    logic [lap3rgb_pkg::WEFF_BITS-1:0]  out_col_inc;
    lap3rgb_pkg::t_border               s0_border;

    assign in_acc      = i_valid && !o_stall;
    assign drain_phase = r_in_row >= h_eff;
    // a drain item inside the frame is a no-op
    assign act         = in_acc && (drain_phase || !i_drain);
    assign emit        = (r_in_row >= lap3rgb_pkg::IROW_BITS'(2)) ||
                         ((r_in_row == lap3rgb_pkg::IROW_BITS'(1)) && (r_in_col != '0));
    assign s0_emit     = act && emit;
    assign px_in       = drain_phase ? '0 : {i_channel_two, i_channel_one, i_channel_zero};
    assign in_col_inc  = {1'b0, r_in_col} + lap3rgb_pkg::WEFF_BITS'(1);
    assign out_col_inc = {1'b0, r_out_col} + lap3rgb_pkg::WEFF_BITS'(1);

    always_comb begin
        s0_border.lf_rep = (r_out_col == '0);
        s0_border.rt_rep = ({1'b0, r_out_col} == (w_eff - lap3rgb_pkg::WEFF_BITS'(1)));
        s0_border.up_rep = (r_out_row == '0);
        s0_border.dn_rep = ({1'b0, r_out_row} == (h_eff - lap3rgb_pkg::IROW_BITS'(1)));
        s0_border.last   = s0_border.rt_rep && s0_border.dn_rep;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_geom) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (act) begin
            if (in_col_inc >= w_eff) begin
                n_in_col = '0;
                n_in_row = r_in_row + lap3rgb_pkg::IROW_BITS'(1);
            end else begin
                n_in_col = in_col_inc[lap3rgb_pkg::COL_BITS-1:0];
            end
            if (emit) begin
                if (s0_border.last) begin
                    // frame done: next frame starts from scratch
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_inc >= w_eff) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + lap3rgb_pkg::OROW_BITS'(1);
                end else begin
                    n_out_col = out_col_inc[lap3rgb_pkg::COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: line memory read-modify-write, window shift, Laplacian
    // ------------------------------------------------------------------------
    logic                               r_s1_act;
    logic                               r_s1_emit;
    logic [lap3rgb_pkg::COL_BITS-1:0]   r_s1_addr;
    logic [PB-1:0]                      r_s1_px;
    logic                               r_s1_fwd;
    lap3rgb_pkg::t_border               r_s1_border;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_act  <= 1'b0;
            r_s1_emit <= 1'b0;
        end else begin
            r_s1_act  <= act;
            r_s1_emit <= s0_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (act) begin
            r_s1_addr   <= r_in_col;
            r_s1_px     <= px_in;
            r_s1_border <= s0_border;
            // memory read collides with the write of the item ahead
            r_s1_fwd    <= r_s1_act && (r_s1_addr == r_in_col);
        end
    end

    // memory word: upper line in the high half, lower line in the low half
    logic [2*PB-1:0]    ram_rd;
    logic [2*PB-1:0]    ram_wr;
    logic [PB-1:0]      u_cur;
    logic [PB-1:0]      l_cur;
    logic [PB-1:0]      r_fwd_upper;
    logic [PB-1:0]      r_fwd_lower;

    assign u_cur  = r_s1_fwd ? r_fwd_upper : ram_rd[2*PB-1:PB];
    assign l_cur  = r_s1_fwd ? r_fwd_lower : ram_rd[PB-1:0];
    assign ram_wr = {l_cur, r_s1_px};

    lap3rgb_ram #(
        .WIDTH (2 * PB),
        .DEPTH (lap3rgb_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_act),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (ram_wr),
        .i_rd_addr (r_in_col),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (r_s1_act) begin
            r_fwd_upper <= l_cur;
            r_fwd_lower <= r_s1_px;
        end
    end

    // window: right column (up/mid/dn) and centre; older columns are never used
    logic [PB-1:0]  r_win_up;
    logic [PB-1:0]  r_win_mid;
    logic [PB-1:0]  r_win_dn;
    logic [PB-1:0]  r_win_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_up  <= '0;
            r_win_mid <= '0;
            r_win_dn  <= '0;
            r_win_ctr <= '0;
        end else if (r_s1_act) begin
            r_win_ctr <= r_win_mid;
            r_win_up  <= u_cur;
            r_win_mid <= l_cur;
            r_win_dn  <= r_s1_px;
        end
    end

    logic [CB-1:0]                              nb_up  [lap3rgb_pkg::NUM_CHANNELS];
    logic [CB-1:0]                              nb_dn  [lap3rgb_pkg::NUM_CHANNELS];
    logic [CB-1:0]                              nb_lf  [lap3rgb_pkg::NUM_CHANNELS];
    logic [CB-1:0]                              nb_rt  [lap3rgb_pkg::NUM_CHANNELS];
    logic [CB-1:0]                              nb_c   [lap3rgb_pkg::NUM_CHANNELS];
    logic signed [lap3rgb_pkg::SUM_BITS-1:0]    lap    [lap3rgb_pkg::NUM_CHANNELS];
    logic [lap3rgb_pkg::SUM_BITS-1:0]           lap_abs[lap3rgb_pkg::NUM_CHANNELS];

    // post-shift window: centre = old mid, left = old centre, right = fresh lower
    always_comb begin
        for (int k = 0; k < lap3rgb_pkg::NUM_CHANNELS; k++) begin
            nb_c[k]  = r_win_mid[k*CB +: CB];
            nb_up[k] = r_win_up[k*CB +: CB];
            nb_dn[k] = r_win_dn[k*CB +: CB];
            nb_lf[k] = r_win_ctr[k*CB +: CB];
            nb_rt[k] = l_cur[k*CB +: CB];
            if (r_s1_border.lf_rep) nb_lf[k] = nb_rt[k];
            if (r_s1_border.rt_rep) nb_rt[k] = nb_lf[k];
            if (r_s1_border.up_rep) nb_up[k] = nb_dn[k];
            if (r_s1_border.dn_rep) nb_dn[k] = nb_up[k];
            lap[k] = $signed(lap3rgb_pkg::SUM_BITS'(nb_up[k]) + lap3rgb_pkg::SUM_BITS'(nb_dn[k])
                           + lap3rgb_pkg::SUM_BITS'(nb_lf[k]) + lap3rgb_pkg::SUM_BITS'(nb_rt[k])
                           - (lap3rgb_pkg::SUM_BITS'(nb_c[k]) << 2));
            lap_abs[k] = lap[k][lap3rgb_pkg::SUM_BITS-1] ? 
                         lap3rgb_pkg::SUM_BITS'(-lap[k]) : lap3rgb_pkg::SUM_BITS'(lap[k]);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: gain and saturation
    // ------------------------------------------------------------------------
    logic                                   r_s2_v;
    logic                                   r_s2_last;
    logic [lap3rgb_pkg::MAG_BITS-1:0]       r_s2_mag [lap3rgb_pkg::NUM_CHANNELS];
    logic [lap3rgb_pkg::PROD_BITS-1:0]      prod     [lap3rgb_pkg::NUM_CHANNELS];
    logic [CB-1:0]                          sat      [lap3rgb_pkg::NUM_CHANNELS];
    lap3rgb_pkg::t_result                   s2_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_emit) begin
            r_s2_last <= r_s1_border.last;
            for (int k = 0; k < lap3rgb_pkg::NUM_CHANNELS; k++) begin
                r_s2_mag[k] <= lap_abs[k][lap3rgb_pkg::MAG_BITS-1:0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < lap3rgb_pkg::NUM_CHANNELS; k++) begin
            prod[k] = lap3rgb_pkg::PROD_BITS'(r_s2_mag[k]) * lap3rgb_pkg::PROD_BITS'(r_gain);
            sat[k]  = (prod[k] > lap3rgb_pkg::PROD_BITS'((1 << CB) - 1)) ?
                      {CB{1'b1}} : prod[k][CB-1:0];
        end
        s2_res.edge_zero  = sat[0];
        s2_res.edge_one   = sat[1];
        s2_res.edge_two   = sat[2];
        s2_res.frame_last = r_s2_last;
    end

    // ------------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------------
    lap3rgb_pkg::t_result                   r_fifo_mem [lap3rgb_pkg::FIFO_DEPTH];
    logic [lap3rgb_pkg::FIFO_PTR_BITS-1:0]  r_wr_ptr;
    logic [lap3rgb_pkg::FIFO_PTR_BITS-1:0]  r_rd_ptr;
    logic [lap3rgb_pkg::FIFO_CNT_BITS-1:0]  r_fifo_cnt;
    logic [lap3rgb_pkg::FIFO_CNT_BITS:0]    occupancy;
    logic                                   push;
    logic                                   pop;
    lap3rgb_pkg::t_result                   head;

    assign push = r_s2_v;
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo_mem[r_wr_ptr] <= s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + lap3rgb_pkg::FIFO_PTR_BITS'(1);
            if (pop)  r_rd_ptr <= r_rd_ptr + lap3rgb_pkg::FIFO_PTR_BITS'(1);
            priority case ({push, pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + lap3rgb_pkg::FIFO_CNT_BITS'(1);
                2'b01:   r_fifo_cnt <= r_fifo_cnt - lap3rgb_pkg::FIFO_CNT_BITS'(1);
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
        end
    end

    // queued plus in-flight results reserve a slot each
    assign occupancy = {1'b0, r_fifo_cnt}
                     + (lap3rgb_pkg::FIFO_CNT_BITS + 1)'(r_s1_emit)
                     + (lap3rgb_pkg::FIFO_CNT_BITS + 1)'(r_s2_v);
    assign o_stall   = occupancy >= (lap3rgb_pkg::FIFO_CNT_BITS + 1)'(lap3rgb_pkg::FIFO_DEPTH);

    assign head         = r_fifo_mem[r_rd_ptr];
    assign o_valid      = (r_fifo_cnt != '0);
    assign o_edge_zero  = head.edge_zero;
    assign o_edge_one   = head.edge_one;
    assign o_edge_two   = head.edge_two;
    assign o_frame_last = head.frame_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (lap3rgb_pkg::FIFO_CNT_BITS + 1)'(lap3rgb_pkg::FIFO_DEPTH))
        else $error("result queue over-committed");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_in_col} < w_eff)
        else $error("input column outside row");

    a_emit_is_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_emit |-> r_s1_act)
        else $error("result without memory access");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_emit && s0_border.last) |=>
            (r_in_row == '0) && (r_in_col == '0) && (r_out_row == '0) && (r_out_col == '0))
        else $error("counters not cleared after frame end");

    a_last_pushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_emit && s0_border.last) |=> ##1 (r_s2_v && r_s2_last))
        else $error("frame end result lost in pipeline");

endmodule
